// ----- rtl/ccrs_pkg.sv -----
// shared types, constants and class tables of the character class range set
package ccrs_pkg;

  localparam int unsigned CHAR_BITS_DEF   = 8;
  localparam int unsigned MAX_RANGES_DEF  = 128;
  localparam int unsigned TABLE_DEPTH     = 128;
  localparam int unsigned ADDR_W          = 7;
  localparam int unsigned FIELD_W         = 8;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  // command codes
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLASS  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // classified request handed from front to engine
  typedef struct packed {
    func_e        func;
    logic [7:0]   first;
    logic [7:0]   last;
    logic [3:0]   code;
    logic [7:0]   idx;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       valid;
    logic [7:0] count;
    logic       ovf;
  } res_t;

  // number of ranges in a named class
  function automatic logic [2:0] class_len(input logic [3:0] code);
    logic [2:0] len;
    case (code)
      4'd0:    len = 3'd3;
      4'd1:    len = 3'd2;
      4'd2:    len = 3'd1;
      4'd3:    len = 3'd2;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd1;
      4'd7:    len = 3'd1;
      4'd8:    len = 3'd1;
      4'd9:    len = 3'd4;
      4'd10:   len = 3'd6;
      4'd11:   len = 3'd5;
      4'd12:   len = 3'd1;
      4'd13:   len = 3'd4;
      4'd14:   len = 3'd3;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // range k of a named class, {first, last}
  function automatic logic [15:0] class_range(input logic [3:0] code, input logic [2:0] k);
    logic [15:0] r;
    case ({code, k})
      {4'd0, 3'd0}:  r = 16'h3039;
      {4'd0, 3'd1}:  r = 16'h415A;
      {4'd0, 3'd2}:  r = 16'h617A;
      {4'd1, 3'd0}:  r = 16'h415A;
      {4'd1, 3'd1}:  r = 16'h617A;
      {4'd2, 3'd0}:  r = 16'h007F;
      {4'd3, 3'd0}:  r = 16'h0909;
      {4'd3, 3'd1}:  r = 16'h2020;
      {4'd4, 3'd0}:  r = 16'h001F;
      {4'd4, 3'd1}:  r = 16'h7F7F;
      {4'd5, 3'd0}:  r = 16'h3039;
      {4'd6, 3'd0}:  r = 16'h217E;
      {4'd7, 3'd0}:  r = 16'h617A;
      {4'd8, 3'd0}:  r = 16'h207E;
      {4'd9, 3'd0}:  r = 16'h212F;
      {4'd9, 3'd1}:  r = 16'h3A40;
      {4'd9, 3'd2}:  r = 16'h5B60;
      {4'd9, 3'd3}:  r = 16'h7B7E;
      {4'd10, 3'd0}: r = 16'h0B0B;
      {4'd10, 3'd1}: r = 16'h0909;
      {4'd10, 3'd2}: r = 16'h0A0A;
      {4'd10, 3'd3}: r = 16'h0C0C;
      {4'd10, 3'd4}: r = 16'h0D0D;
      {4'd10, 3'd5}: r = 16'h2020;
      {4'd11, 3'd0}: r = 16'h0909;
      {4'd11, 3'd1}: r = 16'h0A0A;
      {4'd11, 3'd2}: r = 16'h0C0C;
      {4'd11, 3'd3}: r = 16'h0D0D;
      {4'd11, 3'd4}: r = 16'h2020;
      {4'd12, 3'd0}: r = 16'h415A;
      {4'd13, 3'd0}: r = 16'h3039;
      {4'd13, 3'd1}: r = 16'h415A;
      {4'd13, 3'd2}: r = 16'h617A;
      {4'd13, 3'd3}: r = 16'h5F5F;
      {4'd14, 3'd0}: r = 16'h3039;
      {4'd14, 3'd1}: r = 16'h4146;
      {4'd14, 3'd2}: r = 16'h6166;
      default:       r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/char_class_range_set.sv -----
// top level of the character class range set
//
// Requests enter through push/full: func selects clear, insert range,
// insert named class or read entry. Every request gives exactly one
// result, in order, through empty/pop. The complement view register is
// written through cfg_valid_i/cfg_ready_o/cfg_data_i (always ready).
// A front stage classifies requests into a two-entry command queue; the
// engine works on one command at a time and drops results into a
// two-entry result queue, so the input keeps taking requests while a
// result waits.
// A stalled receiver fills the result queue, then the engine holds its
// finished result and the command queue fills until full is raised.
// Reset empties the table, both queues and clears the complement view.
module char_class_range_set #(
  parameter int unsigned CHAR_BITS  = ccrs_pkg::CHAR_BITS_DEF,
  parameter int unsigned MAX_RANGES = ccrs_pkg::MAX_RANGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func_i,
  input  logic [7:0] range_first_i,
  input  logic [7:0] range_last_i,
  input  logic [3:0] class_code_i,
  input  logic [7:0] entry_index_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] range_low_o,
  output logic [7:0] range_high_o,
  output logic       entry_valid_o,
  output logic [7:0] range_count_o,
  output logic       overflow_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);
  import ccrs_pkg::*;

  cmd_t front_cmd, eng_cmd;
  res_t eng_res, out_res;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;
  logic complement_q;

  // complement view register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      complement_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      complement_q <= cfg_data_i;
    end
  end

  // request classification
  ccrs_front #(.CHAR_BITS(CHAR_BITS)) u_front (
    .func_i        (func_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .class_code_i  (class_code_i),
    .entry_index_i (entry_index_i),
    .cmd_o         (front_cmd)
  );

  // command queue
  ccrs_fifo #(.T(cmd_t), .DEPTH(CMD_QUEUE_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (eng_cmd),
    .empty_o (cmd_empty)
  );

  // table engine
  ccrs_engine #(.CHAR_BITS(CHAR_BITS), .MAX_RANGES(MAX_RANGES)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_i        (eng_cmd),
    .cmd_pop_o    (cmd_pop),
    .complement_i (complement_q),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (eng_res)
  );

  // result queue
  ccrs_fifo #(.T(res_t), .DEPTH(RES_QUEUE_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (eng_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign range_low_o   = out_res.lo;
  assign range_high_o  = out_res.hi;
  assign entry_valid_o = out_res.valid;
  assign range_count_o = out_res.count;
  assign overflow_o    = out_res.ovf;
endmodule

// ----- rtl/ccrs_fifo.sv -----
// small register queue used between front, engine and result port
module ccrs_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (fill_q == (PtrW + 1)'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/ccrs_front.sv -----
// front end: classifies an incoming request into an engine command
module ccrs_front #(
  parameter int unsigned CHAR_BITS = ccrs_pkg::CHAR_BITS_DEF
) (
  input  logic [1:0]     func_i,
  input  logic [7:0]     range_first_i,
  input  logic [7:0]     range_last_i,
  input  logic [3:0]     class_code_i,
  input  logic [7:0]     entry_index_i,
  output ccrs_pkg::cmd_t cmd_o
);
  import ccrs_pkg::*;

  localparam logic [7:0] CharTop = 8'((1 << CHAR_BITS) - 1);

  logic [7:0] first;
  logic [7:0] last;

  // mask to character width, reversed range becomes a single character
  assign first = range_first_i & CharTop;
  assign last  = range_last_i & CharTop;

  always_comb begin
    cmd_o.func  = func_e'(func_i);
    cmd_o.first = first;
    cmd_o.last  = (last < first) ? first : last;
    cmd_o.code  = class_code_i;
    cmd_o.idx   = entry_index_i;
  end
endmodule

// ----- rtl/ccrs_engine.sv -----
// back end: range table in two banks, merge pass, clear and read sequencing
module ccrs_engine #(
  parameter int unsigned CHAR_BITS  = ccrs_pkg::CHAR_BITS_DEF,
  parameter int unsigned MAX_RANGES = ccrs_pkg::MAX_RANGES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ccrs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           complement_i,
  input  logic           res_full_i,
  output logic           res_push_o,
  output ccrs_pkg::res_t res_o
);
  import ccrs_pkg::*;

  localparam logic [7:0] CharTop = 8'((1 << CHAR_BITS) - 1);
  localparam logic [7:0] MaxCnt  = 8'(MAX_RANGES);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'h001,
    ST_LOAD    = 12'h002,
    ST_URD     = 12'h004,
    ST_UPROC   = 12'h008,
    ST_UFIN    = 12'h010,
    ST_UCOMMIT = 12'h020,
    ST_SRD     = 12'h040,
    ST_SDATA   = 12'h080,
    ST_CP      = 12'h100,
    ST_CQ      = 12'h200,
    ST_CE      = 12'h400,
    ST_DONE    = 12'h800
  } state_e;

  state_e      state_q;
  func_e       op_q;
  logic [3:0]  code_q;
  logic [2:0]  k_q;
  logic [7:0]  idx_q;
  logic [7:0]  a_q, b_q;
  logic [7:0]  i_q, n_q;
  logic        placed_q;
  logic        bank_q;
  logic [7:0]  cnt_q;
  logic        fz_q, lt_q;
  logic        lo0z_q, lasttop_q;
  logic [7:0]  res_lo_q, res_hi_q;
  logic        res_valid_q, ovf_q;

  logic [15:0] bank0_mem [TABLE_DEPTH];
  logic [15:0] bank1_mem [TABLE_DEPTH];
  logic [15:0] rd0_q, rd1_q;

  logic [ADDR_W-1:0] raddr;
  logic [15:0] entry;
  logic [7:0]  ent_lo, ent_hi;
  logic        below, above;
  logic        wen, wen_mem;
  logic [15:0] wdata;
  logic [7:0]  comp_cnt, view_cnt;
  logic [7:0]  p_idx, q_idx;
  logic        has_prev, has_next;
  logic [15:0] cls;

  assign entry  = bank_q ? rd1_q : rd0_q;
  assign ent_lo = entry[15:8];
  assign ent_hi = entry[7:0];

  // neighbor tests of the merge pass
  assign below = ({1'b0, ent_hi} + 9'd1) < {1'b0, a_q};
  assign above = {1'b0, ent_lo} > ({1'b0, b_q} + 9'd1);

  // complement view bookkeeping
  assign comp_cnt = (cnt_q == 8'd0) ? 8'd1
                  : cnt_q + 8'd1 - {7'b0, fz_q} - {7'b0, lt_q};
  assign view_cnt = complement_i ? comp_cnt : cnt_q;
  assign p_idx    = fz_q ? idx_q : idx_q - 8'd1;
  assign q_idx    = fz_q ? idx_q + 8'd1 : idx_q;
  assign has_prev = fz_q || (idx_q != 8'd0);
  assign has_next = (q_idx != cnt_q);

  assign cls = class_range(code_q, k_q);

  // read address per state
  always_comb begin
    case (state_q)
      ST_SRD:  raddr = idx_q[ADDR_W-1:0];
      ST_CP:   raddr = p_idx[ADDR_W-1:0];
      ST_CQ:   raddr = q_idx[ADDR_W-1:0];
      default: raddr = i_q[ADDR_W-1:0];
    endcase
  end

  // write of the merged table into the idle bank
  always_comb begin
    wen   = 1'b0;
    wdata = {ent_lo, ent_hi};
    case (state_q)
      ST_UPROC: begin
        wen = below || above;
        if (!below && above && !placed_q) begin
          wdata = {a_q, b_q};
        end
      end
      ST_UFIN: begin
        wen   = !placed_q;
        wdata = {a_q, b_q};
      end
      default: wen = 1'b0;
    endcase
  end
  assign wen_mem = wen && (n_q < MaxCnt);

  // range table banks
  always_ff @(posedge clk_i) begin
    if (wen_mem && bank_q) begin
      bank0_mem[n_q[ADDR_W-1:0]] <= wdata;
    end
    if (wen_mem && !bank_q) begin
      bank1_mem[n_q[ADDR_W-1:0]] <= wdata;
    end
    rd0_q <= bank0_mem[raddr];
    rd1_q <= bank1_mem[raddr];
  end

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_push_o = (state_q == ST_DONE) && !res_full_i;

  always_comb begin
    res_o.lo    = res_lo_q;
    res_o.hi    = res_hi_q;
    res_o.valid = res_valid_q;
    res_o.count = view_cnt;
    res_o.ovf   = ovf_q;
  end

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= FUNC_CLEAR;
      code_q      <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
      placed_q    <= 1'b0;
      bank_q      <= 1'b0;
      cnt_q       <= '0;
      fz_q        <= 1'b0;
      lt_q        <= 1'b0;
      lo0z_q      <= 1'b0;
      lasttop_q   <= 1'b0;
      res_lo_q    <= '0;
      res_hi_q    <= '0;
      res_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      // track first lower and last upper of the table being built
      if (wen) begin
        if (n_q == 8'd0) begin
          lo0z_q <= (wdata[15:8] == 8'd0);
        end
        lasttop_q <= (wdata[7:0] == CharTop);
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            op_q        <= cmd_i.func;
            code_q      <= cmd_i.code;
            idx_q       <= cmd_i.idx;
            a_q         <= cmd_i.first;
            b_q         <= cmd_i.last;
            i_q         <= '0;
            n_q         <= '0;
            placed_q    <= 1'b0;
            k_q         <= '0;
            res_lo_q    <= '0;
            res_hi_q    <= '0;
            res_valid_q <= 1'b0;
            ovf_q       <= 1'b0;
            case (cmd_i.func)
              FUNC_CLEAR: begin
                cnt_q   <= '0;
                fz_q    <= 1'b0;
                lt_q    <= 1'b0;
                state_q <= ST_DONE;
              end
              FUNC_INSERT: state_q <= ST_URD;
              FUNC_CLASS:  state_q <= ST_LOAD;
              FUNC_READ: begin
                if (complement_i) begin
                  state_q <= (cmd_i.idx < comp_cnt) ? ST_CP : ST_DONE;
                end else begin
                  state_q <= (cmd_i.idx < cnt_q) ? ST_SRD : ST_DONE;
                end
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        // next range of a named class
        ST_LOAD: begin
          if (k_q < class_len(code_q)) begin
            a_q      <= cls[15:8] & CharTop;
            b_q      <= cls[7:0] & CharTop;
            i_q      <= '0;
            n_q      <= '0;
            placed_q <= 1'b0;
            state_q  <= ST_URD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_URD: begin
          state_q <= (i_q == cnt_q) ? ST_UFIN : ST_UPROC;
        end
        // one stored range against the new range
        ST_UPROC: begin
          if (below) begin
            n_q     <= n_q + 8'd1;
            i_q     <= i_q + 8'd1;
            state_q <= ST_URD;
          end else if (above) begin
            n_q <= n_q + 8'd1;
            if (!placed_q) begin
              placed_q <= 1'b1;
            end else begin
              i_q     <= i_q + 8'd1;
              state_q <= ST_URD;
            end
          end else begin
            if (ent_lo < a_q) a_q <= ent_lo;
            if (ent_hi > b_q) b_q <= ent_hi;
            i_q     <= i_q + 8'd1;
            state_q <= ST_URD;
          end
        end
        ST_UFIN: begin
          if (!placed_q) begin
            n_q <= n_q + 8'd1;
          end
          state_q <= ST_UCOMMIT;
        end
        // swap banks unless the union does not fit
        ST_UCOMMIT: begin
          if (n_q > MaxCnt) begin
            ovf_q <= 1'b1;
          end else begin
            bank_q <= !bank_q;
            cnt_q  <= n_q;
            fz_q   <= lo0z_q;
            lt_q   <= lasttop_q;
          end
          if (op_q == FUNC_CLASS) begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SRD: state_q <= ST_SDATA;
        ST_SDATA: begin
          res_lo_q    <= ent_lo;
          res_hi_q    <= ent_hi;
          res_valid_q <= 1'b1;
          state_q     <= ST_DONE;
        end
        ST_CP: state_q <= ST_CQ;
        // gap starts after the previous range
        ST_CQ: begin
          res_lo_q <= has_prev ? ent_hi + 8'd1 : 8'd0;
          state_q  <= ST_CE;
        end
        // gap ends before the next range
        ST_CE: begin
          res_hi_q    <= has_next ? ent_lo - 8'd1 : CharTop;
          res_valid_q <= 1'b1;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/ccrs_checker.sv -----
// port level checks of the character class range set, bound to the top
module ccrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] range_low_o,
  input logic [7:0] range_high_o,
  input logic       entry_valid_o,
  input logic       overflow_o
);
  // a valid range is never reversed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && entry_valid_o) |-> (range_low_o <= range_high_o))
    else $error("reversed range returned");

  // non-read results and misses carry zero bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !entry_valid_o) |-> (range_low_o == 8'd0 && range_high_o == 8'd0))
    else $error("bounds not zero without a valid entry");

  // a valid read result never reports overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && entry_valid_o) |-> !overflow_o)
    else $error("overflow on a read result");

  // a waiting result holds while not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(range_low_o) && $stable(range_high_o)))
    else $error("waiting result changed");
endmodule

bind char_class_range_set ccrs_checker u_ccrs_checker (.*);

// ----- sim/tb_top.sv -----
// testbench of char_class_range_set: directed and random requests checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ccrs_pkg::*;

  localparam int CHAR_TOP = 255;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] func_i = '0;
  logic [7:0] range_first_i = '0;
  logic [7:0] range_last_i = '0;
  logic [3:0] class_code_i = '0;
  logic [7:0] entry_index_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] range_low_o;
  logic [7:0] range_high_o;
  logic       entry_valid_o;
  logic [7:0] range_count_o;
  logic       overflow_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;

  char_class_range_set u_top (
    .clk_i, .rst_ni, .push, .full, .func_i, .range_first_i, .range_last_i,
    .class_code_i, .entry_index_i, .empty, .pop, .range_low_o, .range_high_o,
    .entry_valid_o, .range_count_o, .overflow_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i
  );

  // clock
  always #5 clk_i = ~clk_i;

  // predicted class table and view
  int   set_lo[128];
  int   set_hi[128];
  int   set_count;
  bit   view_inverted;
  res_t pending_results[$];
  int   errors;
  bit   quiet;
  int   pop_stall;

  // union of a..b into the predicted table; returns 1 when it does not fit
  function automatic bit merge_range(int a, int b);
    int nl[129];
    int nu[129];
    int n;
    bit placed;
    n = 0;
    placed = 0;
    for (int i = 0; i < set_count; i++) begin
      if (set_hi[i] + 1 < a) begin
        nl[n] = set_lo[i]; nu[n] = set_hi[i]; n++;
      end else if (set_lo[i] > b + 1) begin
        if (!placed) begin
          nl[n] = a; nu[n] = b; n++; placed = 1;
        end
        nl[n] = set_lo[i]; nu[n] = set_hi[i]; n++;
      end else begin
        if (set_lo[i] < a) a = set_lo[i];
        if (set_hi[i] > b) b = set_hi[i];
      end
    end
    if (!placed) begin
      nl[n] = a; nu[n] = b; n++;
    end
    if (n > 128) return 1'b1;
    for (int i = 0; i < n; i++) begin
      set_lo[i] = nl[i]; set_hi[i] = nu[i];
    end
    set_count = n;
    return 1'b0;
  endfunction

  // number of gaps in the complemented view
  function automatic int gap_count();
    int c;
    if (set_count == 0) return 1;
    c = set_count + 1;
    if (set_lo[0] == 0) c--;
    if (set_hi[set_count-1] == CHAR_TOP) c--;
    return c;
  endfunction

  // gap number k of the complemented view
  function automatic bit find_gap(int k, output int lo, output int hi);
    int seen;
    int s;
    int e;
    seen = 0;
    lo = 0;
    hi = 0;
    for (int j = 0; j <= set_count; j++) begin
      s = (j == 0) ? 0 : set_hi[j-1] + 1;
      if (j == set_count) e = CHAR_TOP;
      else begin
        if (set_lo[j] == 0) continue;
        e = set_lo[j] - 1;
      end
      if (s > e) continue;
      if (seen == k) begin
        lo = s; hi = e;
        return 1'b1;
      end
      seen++;
    end
    return 1'b0;
  endfunction

  // named class tables
  function automatic int class_len_of(int code);
    int lens[15] = '{3, 2, 1, 2, 2, 1, 1, 1, 1, 4, 6, 5, 1, 4, 3};
    return lens[code];
  endfunction

  function automatic int class_bound(int code, int k, bit want_first);
    int tab[15][6] = '{
      '{'h3039, 'h415A, 'h617A, 0, 0, 0},
      '{'h415A, 'h617A, 0, 0, 0, 0},
      '{'h007F, 0, 0, 0, 0, 0},
      '{'h0909, 'h2020, 0, 0, 0, 0},
      '{'h001F, 'h7F7F, 0, 0, 0, 0},
      '{'h3039, 0, 0, 0, 0, 0},
      '{'h217E, 0, 0, 0, 0, 0},
      '{'h617A, 0, 0, 0, 0, 0},
      '{'h207E, 0, 0, 0, 0, 0},
      '{'h212F, 'h3A40, 'h5B60, 'h7B7E, 0, 0},
      '{'h0B0B, 'h0909, 'h0A0A, 'h0C0C, 'h0D0D, 'h2020},
      '{'h0909, 'h0A0A, 'h0C0C, 'h0D0D, 'h2020, 0},
      '{'h415A, 0, 0, 0, 0, 0},
      '{'h3039, 'h415A, 'h617A, 'h5F5F, 0, 0},
      '{'h3039, 'h4146, 'h6166, 0, 0, 0}};
    return want_first ? (tab[code][k] >> 8) : (tab[code][k] & 'hFF);
  endfunction

  // apply one request to the predicted table and give its result
  function automatic res_t predict_result(func_e f, int first, int last, int code, int idx);
    res_t r;
    int lo;
    int hi;
    r = '0;
    case (f)
      FUNC_CLEAR: set_count = 0;
      FUNC_INSERT: begin
        if (last < first) last = first;
        r.ovf = merge_range(first, last);
      end
      FUNC_CLASS: begin
        if (code < 15) begin
          for (int k = 0; k < class_len_of(code); k++) begin
            if (merge_range(class_bound(code, k, 1), class_bound(code, k, 0))) r.ovf = 1'b1;
          end
        end
      end
      default: begin
        if (view_inverted) begin
          if (find_gap(idx, lo, hi)) begin
            r.valid = 1'b1; r.lo = 8'(lo); r.hi = 8'(hi);
          end
        end else if (idx < set_count) begin
          r.valid = 1'b1; r.lo = 8'(set_lo[idx]); r.hi = 8'(set_hi[idx]);
        end
      end
    endcase
    r.count = view_inverted ? 8'(gap_count()) : 8'(set_count);
    return r;
  endfunction

  // send one request, predict its result on acceptance; push stays high afterwards
  task automatic send_request(func_e f, int first = 0, int last = 0, int code = 0,
                              int idx = 0);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) @(negedge clk_i) push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    func_i <= f;
    range_first_i <= 8'(first);
    range_last_i <= 8'(last);
    class_code_i <= 4'(code);
    entry_index_i <= 8'(idx);
    do @(posedge clk_i); while (full);
    pending_results.push_back(predict_result(f, first, last, code, idx));
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      send_request(FUNC_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15), $urandom_range(0, 255));
    else if (pick < 50) begin
      int a;
      a = $urandom_range(0, 255);
      if ($urandom_range(0, 3) == 0)
        send_request(FUNC_INSERT, a, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 255));
      else
        send_request(FUNC_INSERT, a, (a + $urandom_range(0, 3)) & 'hFF,
                     $urandom_range(0, 15), $urandom_range(0, 255));
    end else if (pick < 58)
      send_request(FUNC_CLASS, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15), $urandom_range(0, 255));
    else if ($urandom_range(0, 3) == 0)
      send_request(FUNC_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15), $urandom_range(0, 255));
    else
      send_request(FUNC_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15), $urandom_range(0, 70));
  endtask

  // lower push and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk_i) push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // write the complement view register while idle
  task automatic write_view(bit v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    view_inverted = v;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // extremes, every command and special cases
  task automatic test_directed();
    send_request(FUNC_READ, 0, 0, 0, 0);
    send_request(FUNC_INSERT, 0, 0);
    send_request(FUNC_INSERT, 255, 255);
    send_request(FUNC_INSERT, 40, 30);
    send_request(FUNC_INSERT, 41, 50);
    send_request(FUNC_INSERT, 2, 254);
    send_request(FUNC_READ, 0, 0, 0, 0);
    send_request(FUNC_READ, 0, 0, 0, 128);
    send_request(FUNC_READ, 0, 0, 0, 255);
    send_request(FUNC_CLEAR);
    for (int c = 0; c < 16; c++) send_request(FUNC_CLASS, 0, 0, c, 0);
    send_request(FUNC_READ, 0, 0, 0, 2);
  endtask

  // complemented view, including the empty table
  task automatic test_complement();
    write_view(1'b1);
    send_request(FUNC_READ, 0, 0, 0, 0);
    send_request(FUNC_READ, 0, 0, 0, 5);
    send_request(FUNC_CLEAR);
    send_request(FUNC_READ, 0, 0, 0, 0);
    send_request(FUNC_READ, 0, 0, 0, 1);
    send_request(FUNC_INSERT, 0, 10);
    send_request(FUNC_INSERT, 250, 255);
    send_request(FUNC_READ, 0, 0, 0, 0);
    write_view(1'b0);
  endtask

  // fill the table to its last entry, then try more inserts
  task automatic test_full_table();
    send_request(FUNC_CLEAR);
    for (int c = 0; c < 256; c += 2) send_request(FUNC_INSERT, c, c);
    send_request(FUNC_READ, 0, 0, 0, 127);
    send_request(FUNC_READ, 0, 0, 0, 128);
    send_request(FUNC_CLASS, 0, 0, 10, 0);
    write_view(1'b1);
    send_request(FUNC_READ, 0, 0, 0, 127);
    send_request(FUNC_INSERT, 1, 1);
    send_request(FUNC_READ, 0, 0, 0, 0);
    write_view(1'b0);
    send_request(FUNC_CLEAR);
  endtask

  // random phases under changing view, the last without idling
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_view((ph == 4) ? 1'b1 : (ph % 2 == 1) ? 1'b1 : 1'b0);
      if (ph == 4) quiet = 1'b1;
      for (int n = 0; n < 185; n++) begin
        if (n % 70 == 69) send_request(FUNC_CLEAR);
        else send_random();
      end
    end
  endtask

  // result side stalls in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (quiet) begin
      pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 9) == 0) pop_stall = $urandom_range(1, 5);
    end
  end

  // compare each popped result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (range_low_o !== e.lo) begin
          $error("range_low exp %0d got %0d", e.lo, range_low_o); errors++;
        end
        if (range_high_o !== e.hi) begin
          $error("range_high exp %0d got %0d", e.hi, range_high_o); errors++;
        end
        if (entry_valid_o !== e.valid) begin
          $error("entry_valid exp %0d got %0d", e.valid, entry_valid_o); errors++;
        end
        if (range_count_o !== e.count) begin
          $error("range_count exp %0d got %0d", e.count, range_count_o); errors++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow_o); errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    errors = 0;
    quiet = 1'b0;
    pop_stall = 0;
    set_count = 0;
    view_inverted = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed();
    drain_results();
    test_complement();
    test_full_table();
    test_random();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ccrs_pkg.sv
rtl/ccrs_fifo.sv
rtl/ccrs_front.sv
rtl/ccrs_engine.sv
rtl/char_class_range_set.sv
rtl/ccrs_checker.sv
sim/tb_top.sv
